@@ design/sbef_pkg.sv @@
// ----------------------------------------------------------------------------
// sbef_pkg
// Shared types, register indexes, reset values and saturating arithmetic
// helpers for the stereo biquad with error feedback.
// ----------------------------------------------------------------------------
package sbef_pkg;

   // default number of fractional bits in the coefficients
   localparam int FRAC_DEFAULT = 30;

   localparam int SAMPLE_W = 32;
   localparam int ACC_W    = 64;
   localparam int CSR_IDX_W = 3;

   // saturation bounds of one output sample
   localparam logic signed [SAMPLE_W-1:0] Q31_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] Q31_MIN = 32'sh8000_0000;

   // saturation bounds of the accumulator
   localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

   // coefficient reset values
   localparam logic signed [SAMPLE_W-1:0] B0_RESET = 32'sh4000_0000;
   localparam logic signed [SAMPLE_W-1:0] B1_RESET = 32'sh0000_0000;
   localparam logic signed [SAMPLE_W-1:0] B2_RESET = 32'sh0000_0000;
   localparam logic signed [SAMPLE_W-1:0] A1_RESET = 32'sh0000_0000;
   localparam logic signed [SAMPLE_W-1:0] A2_RESET = 32'sh0000_0000;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   // coefficient set shared by both channels
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] b0;
      logic signed [SAMPLE_W-1:0] b1;
      logic signed [SAMPLE_W-1:0] b2;
      logic signed [SAMPLE_W-1:0] a1;
      logic signed [SAMPLE_W-1:0] a2;
   } coef_type;

   // request payload: one stereo frame
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
   } frame_in_type;

   // response payload: one filtered stereo frame
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } frame_out_type;

   // 64-bit add that clips at the signed bounds
   function automatic logic signed [ACC_W-1:0] sat_add64(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

   // 64-bit subtract that clips at the signed bounds
   function automatic logic signed [ACC_W-1:0] sat_sub64(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

endpackage

@@ design/sbef_channel.sv @@
// ----------------------------------------------------------------------------
// sbef_channel
// One direct-form-I biquad section with error feedback. Computes the output
// for the presented sample and updates its history on advance.
// ----------------------------------------------------------------------------
module sbef_channel #(
   parameter int FRAC = sbef_pkg::FRAC_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sbef_pkg::coef_type                     coef,
   input  logic                                   advance,
   input  logic signed [sbef_pkg::SAMPLE_W-1:0]   sample_in,
   output logic signed [sbef_pkg::SAMPLE_W-1:0]   sample_out
);
   import sbef_pkg::*;

   // history and error term
   logic signed [SAMPLE_W-1:0] in_hist0_ff, in_hist1_ff;
   logic signed [SAMPLE_W-1:0] out_hist0_ff, out_hist1_ff;
   logic [FRAC-1:0]            residue_ff, residue_in;

   logic signed [ACC_W-1:0] prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
   logic signed [ACC_W-1:0] acc0, acc1, acc2, acc3, acc4;
   logic signed [ACC_W-1:0] shifted;
   logic                    fits_q31;

   // five independent full products
   assign prod_b0 = ACC_W'(coef.b0) * ACC_W'(sample_in);
   assign prod_b1 = ACC_W'(coef.b1) * ACC_W'(in_hist0_ff);
   assign prod_b2 = ACC_W'(coef.b2) * ACC_W'(in_hist1_ff);
   assign prod_a1 = ACC_W'(coef.a1) * ACC_W'(out_hist0_ff);
   assign prod_a2 = ACC_W'(coef.a2) * ACC_W'(out_hist1_ff);

   // accumulate with the error term, clipping at every later step
   assign acc0 = prod_b0 + $signed({{(ACC_W-FRAC){1'b0}}, residue_ff});
   assign acc1 = sat_add64(acc0, prod_b1);
   assign acc2 = sat_add64(acc1, prod_b2);
   assign acc3 = sat_sub64(acc2, prod_a1);
   assign acc4 = sat_sub64(acc3, prod_a2);

   // new error term, then floor shift and clip to 32 bits
   assign residue_in = acc4[FRAC-1:0];
   assign shifted    = acc4 >>> FRAC;
   assign fits_q31   = (&shifted[ACC_W-1:SAMPLE_W-1]) | ~(|shifted[ACC_W-1:SAMPLE_W-1]);

   always_comb begin
      if (fits_q31) begin
         sample_out = shifted[SAMPLE_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         sample_out = Q31_MIN;
      end else begin
         sample_out = Q31_MAX;
      end
   end

   // history update
   always_ff @(posedge clock) begin
      if (reset) begin
         in_hist0_ff  <= '0;
         in_hist1_ff  <= '0;
         out_hist0_ff <= '0;
         out_hist1_ff <= '0;
         residue_ff   <= '0;
      end else if (advance) begin
         in_hist0_ff  <= sample_in;
         in_hist1_ff  <= in_hist0_ff;
         out_hist0_ff <= sample_out;
         out_hist1_ff <= out_hist0_ff;
         residue_ff   <= residue_in;
      end
   end

`ifndef ASSERT_OFF
   // the output history follows the delivered sample
   a_out_hist: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_hist0_ff == $past(sample_out)) && (out_hist1_ff == $past(out_hist0_ff)))
      else $error("output history not updated from computed sample");

   // the input history follows the taken sample
   a_in_hist: assert property (@(posedge clock) disable iff (reset)
      advance |=> (in_hist0_ff == $past(sample_in)) && (in_hist1_ff == $past(in_hist0_ff)))
      else $error("input history not updated from taken sample");

   // history holds while no request moves
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_hist0_ff) && $stable(residue_ff) && $stable(in_hist0_ff))
      else $error("channel state changed without a request");
`endif

endmodule

@@ design/stereo_biquad_error_feedback_top.sv @@
// ----------------------------------------------------------------------------
// stereo_biquad_error_feedback_top
// Stereo biquad filter with error feedback, one frame per unstalled cycle.
//
// Requests carry one stereo frame (left_in, right_in) on req_data and are
// taken when req_valid is high and req_stall is low. Each response carries
// the filtered frame on rsp_data and is taken when rsp_valid is high and
// rsp_stall is low. The response is registered at the edge that takes the
// request. Throughput is one frame per unstalled cycle, set by the loop from
// each output into the output history of the multiply and accumulate chain.
// While a response waits under rsp_stall the block stalls requests; a response
// taken in the same cycle lets a new request in. The five coefficients are
// written on the csr port, by the user only while the block is idle, which is
// not enforced. Reset is synchronous: coefficients return to b0 = 1.0 and zero
// elsewhere, all history and error terms clear, no response is held.
// ----------------------------------------------------------------------------
module stereo_biquad_error_feedback_top #(
   parameter int FRAC = sbef_pkg::FRAC_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sbef_pkg::frame_in_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sbef_pkg::frame_out_type              rsp_data,
   input  logic                                 csr_write,
   input  logic [sbef_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbef_pkg::SAMPLE_W-1:0]        csr_wdata
);
   import sbef_pkg::*;

   coef_type                   coef_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   frame_out_type              rsp_data_ff, rsp_data_in;
   logic                       req_accept;
   logic signed [SAMPLE_W-1:0] left_y, right_y;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= B0_RESET;
         coef_ff.b1 <= B1_RESET;
         coef_ff.b2 <= B2_RESET;
         coef_ff.a1 <= A1_RESET;
         coef_ff.a2 <= A2_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_B0:  coef_ff.b0 <= csr_wdata;
            CSR_B1:  coef_ff.b1 <= csr_wdata;
            CSR_B2:  coef_ff.b2 <= csr_wdata;
            CSR_A1:  coef_ff.a1 <= csr_wdata;
            CSR_A2:  coef_ff.a2 <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request handshake
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // channel datapaths
   sbef_channel #(.FRAC(FRAC)) u_left (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef_ff),
      .advance    (req_accept),
      .sample_in  (req_data.left_in),
      .sample_out (left_y)
   );

   sbef_channel #(.FRAC(FRAC)) u_right (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef_ff),
      .advance    (req_accept),
      .sample_in  (req_data.right_in),
      .sample_out (right_y)
   );

   assign rsp_data_in = {left_y, right_y};

   // response register
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // nothing is held after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every accepted request yields a response next cycle
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no response");

   // a taken response with no new request leaves the register empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_accept) |=> !rsp_valid)
      else $error("response repeated after it was taken");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo biquad with error feedback. A short
// stimulus table covers the passthrough after reset, coefficient extremes,
// 64-bit and 32-bit saturation and ignored register indexes. Random phases
// then run with fresh coefficient sets. Every response is compared field by
// field against a bit-exact filter predictor. Requests come in random
// bursts, responses are stalled on their own random pattern, and there is
// one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
   import sbef_pkg::*;

   localparam int FRAC            = FRAC_DEFAULT;
   localparam int CLK_HALF        = 5;
   localparam int HOLD_CYCLES     = 80;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int HOLD_PHASE      = 2;
   localparam int DRAIN_PHASE     = 5;
   localparam int RUN_LIMIT       = 2_000_000;
   localparam int CH_LEFT         = 0;
   localparam int CH_RIGHT        = 1;

   // register indexes past the last coefficient, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;
   typedef enum int {COEF_TAME, COEF_FULL, COEF_EXTREME, COEF_MIXED} coef_mode_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_TOGGLE, STALL_HEAVY} stall_mode_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [SAMPLE_W-1:0]   wdata;
      frame_in_type          frame;
      bit                    checked;
      frame_out_type         want;
   } stim_row_type;

   // history and error term of one channel
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
      logic [FRAC-1:0]            err;
   } chan_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   frame_in_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   frame_out_type         rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [SAMPLE_W-1:0]   csr_wdata = '0;

   // predictor state
   coef_type              coef_now;
   chan_state_type        chans [2];
   frame_out_type         filtered_frames [$];
   stim_row_type          directed_rows [$];

   int                    frames_sent = 0;
   int                    coef_writes = 0;
   int                    responses_checked = 0;
   int                    mismatch_count = 0;
   int                    burst_left = 0;
   bit                    gaps_off = 1'b0;
   bit                    hold_start = 1'b0;

   stereo_biquad_error_feedback_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // exact 64-bit product of two signed samples
   function automatic logic signed [ACC_W-1:0] widen_mul(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [ACC_W-1:0] wa;
      logic signed [ACC_W-1:0] wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   // add with clipping at the 64-bit bounds
   function automatic logic signed [ACC_W-1:0] clip_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W-1:0] s;
      s = a + b;
      if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
         return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end
      return s;
   endfunction

   // subtract with clipping at the 64-bit bounds
   function automatic logic signed [ACC_W-1:0] clip_sub(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W-1:0] s;
      s = a - b;
      if (a[ACC_W-1] != b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
         return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end
      return s;
   endfunction

   // one second-order section step on one channel, updates its history
   function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input int                         ch,
      input logic signed [SAMPLE_W-1:0] x
   );
      logic signed [ACC_W-1:0]    acc;
      logic signed [ACC_W-1:0]    shifted;
      logic signed [SAMPLE_W-1:0] y;
      acc = widen_mul(coef_now.b0, x) + $signed({{(ACC_W-FRAC){1'b0}}, chans[ch].err});
      acc = clip_add(acc, widen_mul(coef_now.b1, chans[ch].x1));
      acc = clip_add(acc, widen_mul(coef_now.b2, chans[ch].x2));
      acc = clip_sub(acc, widen_mul(coef_now.a1, chans[ch].y1));
      acc = clip_sub(acc, widen_mul(coef_now.a2, chans[ch].y2));
      chans[ch].err = acc[FRAC-1:0];
      shifted = acc >>> FRAC;
      if (shifted > Q31_MAX) begin
         y = Q31_MAX;
      end else if (shifted < Q31_MIN) begin
         y = Q31_MIN;
      end else begin
         y = shifted[SAMPLE_W-1:0];
      end
      chans[ch].x2 = chans[ch].x1;
      chans[ch].x1 = x;
      chans[ch].y2 = chans[ch].y1;
      chans[ch].y1 = y;
      return y;
   endfunction

   function automatic frame_out_type predict_frame(input frame_in_type f);
      frame_out_type o;
      o.left_out  = filter_sample(CH_LEFT, f.left_in);
      o.right_out = filter_sample(CH_RIGHT, f.right_in);
      return o;
   endfunction

   function automatic void add_frame_row(
      input logic signed [SAMPLE_W-1:0] l,
      input logic signed [SAMPLE_W-1:0] r,
      input bit                         checked,
      input logic signed [SAMPLE_W-1:0] want_l,
      input logic signed [SAMPLE_W-1:0] want_r
   );
      stim_row_type row;
      row.kind            = ROW_FRAME;
      row.idx             = '0;
      row.wdata           = '0;
      row.frame.left_in   = l;
      row.frame.right_in  = r;
      row.checked         = checked;
      row.want.left_out   = want_l;
      row.want.right_out  = want_r;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr_row(
      input logic [CSR_IDX_W-1:0] idx,
      input logic [SAMPLE_W-1:0]  val
   );
      stim_row_type row;
      row         = '{kind: ROW_CSR, idx: idx, wdata: val, frame: '0, checked: 1'b0,
                      want: '0};
      directed_rows.push_back(row);
   endfunction

   // coefficient draw, tame sets keep the filter stable and mostly unsaturated
   function automatic logic [SAMPLE_W-1:0] pick_coef(
      input coef_mode_type        mode,
      input logic [CSR_IDX_W-1:0] idx
   );
      coef_mode_type m;
      int            v;
      m = mode;
      if (mode == COEF_MIXED) begin
         m = coef_mode_type'($urandom_range(0, 2));
      end
      case (m)
         COEF_FULL: begin
            v = $urandom;
         end
         COEF_EXTREME: begin
            case ($urandom_range(0, 3))
               0: v = Q31_MIN;
               1: v = Q31_MAX;
               2: v = 0;
               default: v = B0_RESET;
            endcase
         end
         default: begin
            if (idx == CSR_A2) begin
               v = $urandom_range(0, 1 << 29);
            end else if (idx == CSR_A1) begin
               v = int'($urandom_range(0, 1 << 30)) - (1 << 29);
            end else begin
               v = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            end
         end
      endcase
      return v;
   endfunction

   // mostly full-range samples, some small values and some extremes
   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      int v;
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 2000)) - 1000;
         1: begin
            case ($urandom_range(0, 3))
               0: v = Q31_MIN;
               1: v = Q31_MAX;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // offer one request and hold it until the block takes it
   task automatic offer_frame(
      input frame_in_type  f,
      input bit            checked,
      input frame_out_type want
   );
      frame_out_type guess;
      req_valid <= 1'b1;
      req_data  <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = predict_frame(f);
      filtered_frames.push_back(checked ? want : guess);
      frames_sent++;
   endtask

   // burst pacing of the sender
   task automatic pace();
      if (gaps_off || burst_left > 0) begin
         if (burst_left > 0) burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // stop offering until every pending response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (filtered_frames.size() != 0) @(posedge clock);
   endtask

   // coefficient write, only once the block has gone idle
   task automatic write_coef(
      input logic [CSR_IDX_W-1:0] idx,
      input logic [SAMPLE_W-1:0]  val
   );
      wait_for_drain();
      repeat (2) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_B0: coef_now.b0 = val;
         CSR_B1: coef_now.b1 = val;
         CSR_B2: coef_now.b2 = val;
         CSR_A1: coef_now.a1 = val;
         CSR_A2: coef_now.a2 = val;
         default: ;
      endcase
      coef_writes++;
   endtask

   // stimulus: directed table, then random phases
   initial begin : stimulus
      stim_row_type  row;
      frame_in_type  f;
      coef_mode_type mode;
      coef_now = '{b0: B0_RESET, b1: B1_RESET, b2: B2_RESET, a1: A1_RESET, a2: A2_RESET};
      chans[CH_LEFT]  = '0;
      chans[CH_RIGHT] = '0;

      // unity gain after reset, output equals input
      add_frame_row(Q31_MAX, Q31_MIN, 1'b1, Q31_MAX, Q31_MIN);
      add_frame_row(Q31_MIN, Q31_MAX, 1'b1, Q31_MIN, Q31_MAX);
      add_frame_row(0, -1, 1'b1, 0, -1);
      add_frame_row(1, -2, 1'b1, 1, -2);
      // gain of minus two, output clips to the 32-bit bounds
      add_csr_row(CSR_B0, Q31_MIN);
      add_frame_row(Q31_MIN, Q31_MAX, 1'b1, Q31_MAX, Q31_MIN);
      add_frame_row(-1, 1, 1'b1, 2, -2);
      add_frame_row(0, 0, 1'b1, 0, 0);
      // tiny gain, error term builds up
      add_csr_row(CSR_B0, 1);
      add_frame_row(1, -1, 1'b0, 0, 0);
      add_frame_row(Q31_MAX, Q31_MIN, 1'b0, 0, 0);
      add_frame_row(Q31_MAX, Q31_MIN, 1'b0, 0, 0);
      add_frame_row(12345, -12345, 1'b0, 0, 0);
      // accumulator clipping at both 64-bit bounds
      add_csr_row(CSR_B1, Q31_MIN);
      add_csr_row(CSR_B2, Q31_MIN);
      add_csr_row(CSR_A1, Q31_MAX);
      add_csr_row(CSR_A2, Q31_MAX);
      add_csr_row(CSR_B0, Q31_MIN);
      repeat (4) add_frame_row(Q31_MIN, Q31_MAX, 1'b0, 0, 0);
      repeat (2) add_frame_row(Q31_MAX, Q31_MIN, 1'b0, 0, 0);
      // writes to unused indexes change nothing
      add_csr_row(CSR_SPARE_LO, '0);
      add_csr_row(CSR_SPARE_HI, '1);
      add_frame_row(32'sh1234_5678, 32'shEDCB_A987, 1'b0, 0, 0);
      // opposite extremes on every coefficient
      add_csr_row(CSR_B0, Q31_MAX);
      add_csr_row(CSR_B1, Q31_MAX);
      add_csr_row(CSR_B2, Q31_MAX);
      add_csr_row(CSR_A1, Q31_MIN);
      add_csr_row(CSR_A2, Q31_MIN);
      add_frame_row(Q31_MAX, Q31_MIN, 1'b0, 0, 0);
      add_frame_row(Q31_MIN, Q31_MAX, 1'b0, 0, 0);
      add_frame_row(0, 0, 1'b0, 0, 0);
      add_frame_row(-1, 1, 1'b0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(0, 12);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            write_coef(row.idx, row.wdata);
         end else begin
            offer_frame(row.frame, row.checked, row.want);
            pace();
         end
      end

      // random phases, each with a fresh coefficient set
      for (int p = 0; p < PHASES; p++) begin
         mode = coef_mode_type'(p % 4);
         for (int r = CSR_B0; r <= CSR_A2; r++) begin
            write_coef(CSR_IDX_W'(r), pick_coef(mode, CSR_IDX_W'(r)));
         end
         if ($urandom_range(0, 1) == 1) begin
            write_coef(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), $urandom);
         end
         // long output hold while requests keep coming
         if (p == HOLD_PHASE) begin
            gaps_off   = 1'b1;
            hold_start = 1'b1;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (p == DRAIN_PHASE && k == ITEMS_PER_PHASE / 2) begin
               wait_for_drain();
            end
            f.left_in  = rand_sample();
            f.right_in = rand_sample();
            offer_frame(f, 1'b0, '0);
            pace();
         end
         gaps_off = 1'b0;
      end

      wait_for_drain();
      repeat (4) @(posedge clock);
      $display("Checked %0d responses for %0d requests across %0d coefficient writes,",
               responses_checked, frames_sent, coef_writes);
      $display("including clipping, error feedback, ignored indexes and a long output hold");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // response stall pattern, with one long hold on request
   initial begin : receiver
      stall_mode_type smode;
      int             seg_left;
      int             hold_left;
      smode     = STALL_NONE;
      seg_left  = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               smode    = stall_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (smode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // compare each taken response with the oldest pending frame
   always @(posedge clock) begin
      frame_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_frames.size() == 0) begin
            $error("response with nothing pending: left_out %0d right_out %0d",
                   $signed(rsp_data.left_out), $signed(rsp_data.right_out));
            mismatch_count++;
         end else begin
            want = filtered_frames.pop_front();
            responses_checked++;
            if (rsp_data.left_out !== want.left_out) begin
               $error("left_out: expected %0d, got %0d",
                      $signed(want.left_out), $signed(rsp_data.left_out));
               mismatch_count++;
            end
            if (rsp_data.right_out !== want.right_out) begin
               $error("right_out: expected %0d, got %0d",
                      $signed(want.right_out), $signed(rsp_data.right_out));
               mismatch_count++;
            end
         end
      end
   end

   // hard stop if the run hangs
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Timeout with %0d responses still pending", filtered_frames.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
design/sbef_pkg.sv
design/sbef_channel.sv
design/stereo_biquad_error_feedback_top.sv
tb/tb_top.sv
